// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL of the range filter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising i_clk edge, off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Property that must hold at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/mer_pkg.sv -----
// ----------------------------------------------------------------------------
// mer_pkg
// Types and constants shared by the median/average range filter.
// ----------------------------------------------------------------------------
package mer_pkg;

    localparam int DIST_W   = 16;
    localparam int AVG_W    = 24;
    localparam int FRAC_W   = 8;
    localparam int WEIGHT_W = 16;
    localparam int PROD_W   = AVG_W + WEIGHT_W;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd19661;
    localparam logic [PROD_W:0]     ROUND_HALF   = (PROD_W + 1)'(32768);

    // Per-cycle commands to the cell row
    typedef struct packed {
        logic load;
        logic rank;
    } t_cell_ctrl;

    // Sample circulating through the row during ranking
    typedef struct packed {
        logic [DIST_W-1:0] val;
        logic              vld;
    } t_token;

endpackage

// ----- rtl/core/mer_cell.sv -----
// ----------------------------------------------------------------------------
// mer_cell
// One window slot: holds a sample, shifts it on load, and counts how many
// circulating samples rank below it while the token row rotates.
// ----------------------------------------------------------------------------
module mer_cell #(
    parameter int IDX_W    = 3,
    parameter int CNT_W    = 3,
    parameter int CELL_IDX = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mer_pkg::t_cell_ctrl       i_ctrl,
    input  logic [mer_pkg::DIST_W-1:0] i_sample,
    input  logic                      i_valid,
    input  mer_pkg::t_token           i_tok,
    input  logic [IDX_W-1:0]          i_tok_idx,
    output logic [mer_pkg::DIST_W-1:0] o_sample,
    output logic                      o_valid,
    output mer_pkg::t_token           o_tok,
    output logic [IDX_W-1:0]          o_tok_idx,
    output logic [CNT_W-1:0]          o_cnt
);
    import mer_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [DIST_W-1:0] r_sample;
    logic              r_valid;
    t_token            r_tok;
    logic [IDX_W-1:0]  r_tok_idx;
    logic [CNT_W-1:0]  r_cnt;
    logic              below;

    // tie on equal values broken by slot index
    assign below = r_tok.vld && ((r_tok.val < r_sample) ||
                                 ((r_tok.val == r_sample) && (r_tok_idx < MY_IDX)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok.vld <= 1'b0;
            r_cnt     <= '0;
        end else if (i_ctrl.load) begin
            r_sample  <= i_sample;
            r_valid   <= i_valid;
            r_tok.val <= i_sample;
            r_tok.vld <= i_valid;
            r_tok_idx <= MY_IDX;
            r_cnt     <= '0;
        end else if (i_ctrl.rank) begin
            r_tok     <= i_tok;
            r_tok_idx <= i_tok_idx;
            if (below) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    assign o_sample  = r_sample;
    assign o_valid   = r_valid;
    assign o_tok     = r_tok;
    assign o_tok_idx = r_tok_idx;
    assign o_cnt     = r_cnt;

endmodule

// ----- rtl/core/mer_ema.sv -----
// ----------------------------------------------------------------------------
// mer_ema
// Exponential average in Q16.8: first sample loads, later samples move the
// average by weight * difference, rounded half away from zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mer_ema (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mer_pkg::DIST_W-1:0]    i_median,
    input  logic [mer_pkg::WEIGHT_W-1:0]  i_weight,
    output logic                          o_done,
    output logic [mer_pkg::AVG_W-1:0]     o_avg
);
    import mer_pkg::*;

    typedef enum logic [1:0] {
        E_IDLE,
        E_MUL,
        E_UPD
    } t_ema_state;

    t_ema_state        r_state;
    logic              r_primed;
    logic              r_done;
    logic              r_up;
    logic [AVG_W-1:0]  r_avg;
    logic [AVG_W-1:0]  r_mag;
    logic [PROD_W-1:0] r_prod;
    logic [AVG_W-1:0]  target;
    logic [PROD_W:0]   rounded;
    logic [AVG_W-1:0]  delta;

    assign target  = {i_median, {FRAC_W{1'b0}}};
    assign rounded = {1'b0, r_prod} + ROUND_HALF;
    assign delta   = rounded[PROD_W-1:WEIGHT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= E_IDLE;
            r_primed <= 1'b0;
            r_done   <= 1'b0;
            r_avg    <= '0;
        end else begin
            r_done <= ((r_state == E_IDLE) && i_start && !r_primed) ||
                      (r_state == E_UPD);
            unique case (r_state)
                E_IDLE: begin
                    if (i_start) begin
                        if (!r_primed) begin
                            r_avg    <= target;
                            r_primed <= 1'b1;
                        end else begin
                            r_up    <= (target >= r_avg);
                            r_mag   <= (target >= r_avg) ? target - r_avg : r_avg - target;
                            r_state <= E_MUL;
                        end
                    end
                end
                E_MUL: begin
                    r_prod  <= PROD_W'(i_weight) * PROD_W'(r_mag);
                    r_state <= E_UPD;
                end
                E_UPD: begin
                    r_avg   <= r_up ? r_avg + delta : r_avg - delta;
                    r_state <= E_IDLE;
                end
                default: r_state <= E_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_avg  = r_avg;

    `ASSERT_CLK(a_primed_holds, !$fell(r_primed), "average lost its primed mark")
    `ASSERT_CLK(a_done_from_load_or_upd,
        r_done |-> ($past(r_state) == E_UPD) || ($past(i_start) && !$past(r_primed)),
        "average done without a load or update")

endmodule

// ----- rtl/core/median_ema_range_filter.sv -----
// ----------------------------------------------------------------------------
// median_ema_range_filter
// Range smoother: median over the last WINDOW_LENGTH valid readings through a
// row of ranking cells, then an exponential average in Q16.8.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                   tuser
//  s_axis    in   [15:0] range_mm                         sample_valid
//  m_axis    out  [15:0] raw_distance, [39:16] smoothed   raw_valid
//  cfg       in   i_cfg_wdata = smoothing_weight (Q0.16)  -
//
//  A valid reading passes through the rotation of samples through the cell row,
//  the median select and the multiply/update steps of the average (the first
//  valid one after reset loads it without them); an invalid one skips to output.
//  One transaction is in work at a time; s_axis_tready is high while idle, also
//  while a result still waits in the output register.
//  Reset is synchronous, active low; m_axis_tready low stalls the finish step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module median_ema_range_filter #(
    parameter int WINDOW_LENGTH = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mer_pkg::WEIGHT_W-1:0]  i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,   // [15:0] range_mm
    input  logic                          s_axis_tuser,   // [0] sample_valid
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [39:0]                   m_axis_tdata,   // [15:0] raw, [39:16] smoothed
    output logic                          m_axis_tuser    // [0] raw_valid
);
    import mer_pkg::*;

    localparam int N     = WINDOW_LENGTH;
    localparam int IDX_W = (N > 1) ? $clog2(N) : 1;
    localparam int CNT_W = $clog2(N + 1);
    localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(N);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(N - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RANK,
        S_SEL,
        S_START,
        S_WAIT,
        S_OUT
    } t_state;

    t_state            r_state;
    logic [WEIGHT_W-1:0] r_weight;
    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  r_step;
    logic [DIST_W-1:0] r_raw_dist;
    logic              r_raw_valid;
    logic [DIST_W-1:0] r_median;
    logic              r_o_valid;
    logic [39:0]       r_o_data;
    logic              r_o_user;

    logic              accept;
    t_cell_ctrl        ctrl;
    logic [CNT_W-1:0]  mid_rank;
    logic [DIST_W-1:0] median_sel;
    logic              ema_done;
    logic [AVG_W-1:0]  ema_avg;

    logic [DIST_W-1:0] cell_sample [N];
    logic              cell_valid  [N];
    t_token            cell_tok    [N];
    logic [IDX_W-1:0]  cell_idx    [N];
    logic [CNT_W-1:0]  cell_cnt    [N];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign ctrl.load     = accept && s_axis_tuser;
    assign ctrl.rank     = (r_state == S_RANK);
    assign mid_rank      = r_fill >> 1;

    for (genvar g = 0; g < N; g++) begin : g_cell
        localparam int PREV = (g == 0) ? N - 1 : g - 1;
        logic [DIST_W-1:0] shift_in;
        logic              shift_vld;

        assign shift_in  = (g == 0) ? s_axis_tdata : cell_sample[PREV];
        assign shift_vld = (g == 0) ? 1'b1 : cell_valid[PREV];

        mer_cell #(
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (ctrl),
            .i_sample  (shift_in),
            .i_valid   (shift_vld),
            .i_tok     (cell_tok[PREV]),
            .i_tok_idx (cell_idx[PREV]),
            .o_sample  (cell_sample[g]),
            .o_valid   (cell_valid[g]),
            .o_tok     (cell_tok[g]),
            .o_tok_idx (cell_idx[g]),
            .o_cnt     (cell_cnt[g])
        );
    end

    // ranks are unique among filled cells, so at most one matches
    always_comb begin
        median_sel = '0;
        for (int i = 0; i < N; i++) begin
            if (cell_valid[i] && (cell_cnt[i] == mid_rank)) begin
                median_sel = median_sel | cell_sample[i];
            end
        end
    end

    mer_ema u_ema (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_START),
        .i_median (r_median),
        .i_weight (r_weight),
        .o_done   (ema_done),
        .o_avg    (ema_avg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WEIGHT_RESET;
        end else if (i_cfg_we) begin
            r_weight <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_step    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && m_axis_tready && (r_state != S_OUT)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_raw_dist  <= s_axis_tdata;
                        r_raw_valid <= s_axis_tuser;
                        r_step      <= '0;
                        if (s_axis_tuser) begin
                            if (r_fill != FILL_MAX) begin
                                r_fill <= r_fill + CNT_W'(1);
                            end
                            r_state <= S_RANK;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_RANK: begin
                    r_step <= r_step + CNT_W'(1);
                    if (r_step == LAST_STEP) begin
                        r_state <= S_SEL;
                    end
                end
                S_SEL: begin
                    r_median <= median_sel;
                    r_state  <= S_START;
                end
                S_START: r_state <= S_WAIT;
                S_WAIT: begin
                    if (ema_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_o_valid || m_axis_tready) begin
                        r_o_valid <= 1'b1;
                        r_o_data  <= {ema_avg, r_raw_dist};
                        r_o_user  <= r_raw_valid;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_user;

    `ASSERT_CLK(a_fill_bound, r_fill <= FILL_MAX, "fill count beyond window")
    `ASSERT_CLK(a_invalid_skips_rank,
        (accept && !s_axis_tuser) |=> (r_state == S_OUT), "invalid reading went to ranking")
    `ASSERT_CLK(a_done_only_waiting, ema_done |-> (r_state == S_WAIT),
        "average finished outside wait step")

endmodule

// ----- verif/median_ema_range_filter_checker.sv -----
// ----------------------------------------------------------------------------
// median_ema_range_filter_checker
// Watches the reading and result streams of the range filter. Keeps its own
// window of samples, median and Q16.8 average, predicts the result of each
// accepted reading and compares each result transaction field by field.
// ----------------------------------------------------------------------------
module median_ema_range_filter_checker #(
    parameter int WINDOW_LENGTH = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mer_pkg::WEIGHT_W-1:0]  i_cfg_wdata,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [15:0]                   i_s_tdata,   // [15:0] range_mm
    input  logic                          i_s_tuser,   // [0] sample_valid
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [39:0]                   i_m_tdata,   // [15:0] raw_distance, [39:16] smoothed
    input  logic                          i_m_tuser,   // [0] raw_valid
    output int                            o_fail_count,
    output int                            o_pending
);
    import mer_pkg::*;

    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic [DIST_W-1:0] raw_distance;
        logic              raw_valid;
        logic [AVG_W-1:0]  smoothed_distance;
    } t_filtered_reading;

    logic [DIST_W-1:0]   window_ring [WINDOW_LENGTH];
    int unsigned         write_slot;
    int unsigned         fill_count;
    logic [AVG_W-1:0]    average_q16_8;
    logic                average_loaded;
    logic [WEIGHT_W-1:0] smoothing_weight;
    t_filtered_reading   predicted_readings_q [$];
    int                  mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string what, input logic [AVG_W-1:0] got,
                                   input logic [AVG_W-1:0] want);
        if (mismatches < PRINT_CAP)
            $display("%0t: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Upper middle of the filled entries; all entries once the window is full
    function automatic logic [DIST_W-1:0] window_median();
        logic [DIST_W-1:0] sorted [WINDOW_LENGTH];
        logic [DIST_W-1:0] key;
        int                j;
        for (int i = 0; i < WINDOW_LENGTH; i++)
            sorted[i] = window_ring[i];
        for (int i = 1; i < int'(fill_count); i++) begin
            key = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > key) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end
        return sorted[fill_count / 2];
    endfunction

    function automatic void filter_reading(input logic [DIST_W-1:0] sample_mm);
        logic [AVG_W-1:0]  target;
        logic [AVG_W-1:0]  magnitude;
        logic [PROD_W:0]   product;
        logic [AVG_W-1:0]  step;
        window_ring[write_slot] = sample_mm;
        write_slot = (write_slot + 1) % WINDOW_LENGTH;
        if (fill_count < WINDOW_LENGTH)
            fill_count++;
        target = {window_median(), {FRAC_W{1'b0}}};
        if (!average_loaded) begin
            average_q16_8 = target;
            average_loaded = 1'b1;
        end else begin
            magnitude = (target >= average_q16_8) ? target - average_q16_8
                                                  : average_q16_8 - target;
            product = (PROD_W+1)'(smoothing_weight) * (PROD_W+1)'(magnitude) + ROUND_HALF;
            step = AVG_W'(product >> WEIGHT_W);
            if (target >= average_q16_8)
                average_q16_8 = average_q16_8 + step;
            else
                average_q16_8 = average_q16_8 - step;
        end
    endfunction

    always @(posedge i_clk) begin
        t_filtered_reading want;
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_LENGTH; i++)
                window_ring[i] = '0;
            write_slot = 0;
            fill_count = 0;
            average_q16_8 = '0;
            average_loaded = 1'b0;
            smoothing_weight = WEIGHT_RESET;
            predicted_readings_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we)
                smoothing_weight = i_cfg_wdata;
            if (i_m_tvalid && i_m_tready) begin
                if (predicted_readings_q.size() == 0) begin
                    report_mismatch("unexpected result", AVG_W'(i_m_tdata[15:0]), '0);
                end else begin
                    want = predicted_readings_q.pop_front();
                    if (i_m_tdata[15:0] !== want.raw_distance)
                        report_mismatch("raw_distance", AVG_W'(i_m_tdata[15:0]),
                                        AVG_W'(want.raw_distance));
                    if (i_m_tuser !== want.raw_valid)
                        report_mismatch("raw_valid", AVG_W'(i_m_tuser),
                                        AVG_W'(want.raw_valid));
                    if (i_m_tdata[39:16] !== want.smoothed_distance)
                        report_mismatch("smoothed_distance", i_m_tdata[39:16],
                                        want.smoothed_distance);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser)
                    filter_reading(i_s_tdata);
                want.raw_distance = i_s_tdata;
                want.raw_valid = i_s_tuser;
                want.smoothed_distance = average_q16_8;
                predicted_readings_q.push_back(want);
            end
            o_pending <= predicted_readings_q.size();
        end
    end

endmodule

// ----- verif/median_ema_range_filter_tb.sv -----
// ----------------------------------------------------------------------------
// median_ema_range_filter_tb
// Drives range readings into the filter under several smoothing weights:
// a directed opening (empty window, partial window, extremes, invalid hold,
// zero and full weight), then random phases of clustered, outlier and noise
// readings with random gaps and back-pressure, one long receiver hold-off.
// ----------------------------------------------------------------------------
module median_ema_range_filter_tb;
    import mer_pkg::*;

    localparam int WINDOW_LENGTH   = 5;
    localparam int ITEM_LATENCY    = WINDOW_LENGTH + 7;
    localparam int IDLE_LIMIT      = 5000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_COUNT     = 7;
    localparam int PHASE_ITEMS     = 250;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [WEIGHT_W-1:0] i_cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata = '0;
    logic                s_axis_tuser = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [39:0]         m_axis_tdata;
    logic                m_axis_tuser;

    int                  fail_count;
    int                  pending;
    bit                  steady = 1'b0;
    bit                  hold_off_req = 1'b0;
    logic [DIST_W-1:0]   track_base = 16'd1500;

    median_ema_range_filter #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    median_ema_range_filter_checker #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) range_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones; none in steady stretches
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Slowly wandering target with jitter, plus outliers and full-range noise
    function automatic logic [DIST_W-1:0] next_distance();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            track_base = DIST_W'($urandom_range(0, 65535));
        if (r < 10) begin
            case ($urandom_range(0, 3))
                0:       return 16'h0000;
                1:       return 16'hFFFF;
                2:       return 16'h0001;
                default: return 16'hFFFE;
            endcase
        end
        if (r < 40)
            return DIST_W'($urandom_range(0, 65535));
        track_base = track_base + DIST_W'($urandom_range(0, 64)) - DIST_W'(32);
        return track_base + DIST_W'($urandom_range(0, 16)) - DIST_W'(8);
    endfunction

    task automatic send_reading(input logic [DIST_W-1:0] sample_mm, input logic valid);
        int gap;
        gap = idle_span();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample_mm;
        s_axis_tuser  <= valid;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Stop offering and wait for every result; block is idle afterwards
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (ITEM_LATENCY) @(posedge i_clk);
    endtask

    task automatic write_weight(input logic [WEIGHT_W-1:0] weight);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= weight;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random(input int count, input bit with_hold);
        for (int i = 0; i < count; i++) begin
            if (i % 64 == 0)
                steady = ($urandom_range(0, 4) == 0);
            if (with_hold && i == count / 3)
                hold_off_req = 1'b1;
            send_reading(next_distance(), $urandom_range(0, 99) < 85);
        end
        steady = 1'b0;
    endtask

    // Receiver side
    initial begin
        int span;
        @(posedge i_clk);
        forever begin
            span = $urandom_range(0, 1) ? 0 : idle_span();
            if (hold_off_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (span == 0) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat (span) @(posedge i_clk);
            end
        end
    end

    // Watchdog on cycles without any transaction
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("median_ema_range_filter verification failed");
        $finish;
    end

    initial begin
        logic [WEIGHT_W-1:0] phase_weight [PHASE_COUNT];
        phase_weight[0] = WEIGHT_RESET;
        phase_weight[1] = 16'hFFFF;
        phase_weight[2] = 16'h0001;
        phase_weight[3] = 16'h8000;
        phase_weight[4] = WEIGHT_W'($urandom_range(0, 65535));
        phase_weight[5] = 16'h0000;
        phase_weight[6] = WEIGHT_W'($urandom_range(0, 65535));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset weight: nothing valid yet, then the window filling up
        send_reading(16'h0000, 1'b0);
        send_reading(16'hFFFF, 1'b0);
        send_reading(16'hFFFF, 1'b1);
        send_reading(16'h0000, 1'b1);
        send_reading(16'h0001, 1'b1);
        send_reading(16'h8000, 1'b1);
        send_reading(16'h5555, 1'b1);
        send_reading(16'hAAAA, 1'b1);
        send_reading(16'h1234, 1'b0);
        send_reading(16'hFFFF, 1'b1);
        send_reading(16'hFFFF, 1'b1);
        send_reading(16'hFFFF, 1'b1);
        send_reading(16'h0000, 1'b1);
        settle();

        // zero weight holds the average
        write_weight(16'h0000);
        send_reading(16'h0000, 1'b1);
        send_reading(16'h0000, 1'b1);
        send_reading(16'h0000, 1'b1);
        settle();

        // full weight
        write_weight(16'hFFFF);
        send_reading(16'h0000, 1'b1);
        send_reading(16'h0000, 1'b1);
        send_reading(16'h0000, 1'b1);
        send_reading(16'hFFFF, 1'b0);
        send_reading(16'hFFFF, 1'b1);
        settle();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_weight(phase_weight[p]);
            run_random(PHASE_ITEMS, p == 3);
            settle();
        end

        repeat (4 * ITEM_LATENCY) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("median_ema_range_filter verification clean");
        else
            $display("median_ema_range_filter verification failed");
        $finish;
    end

endmodule
